/* design/iir_filter_df2t_assert.svh */
// Assertion macros for the IIR filter checker.
// Each macro takes a label, a clock, a reset, a trigger and a consequence.
`ifndef IIR_FILTER_DF2T_ASSERT_SVH
`define IIR_FILTER_DF2T_ASSERT_SVH

// Consequence must hold in the same cycle as the trigger.
`define IIRDF2T_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iir filter check failed");

// Consequence must hold in the cycle after the trigger.
`define IIRDF2T_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iir filter check failed");

`endif

/* design/iirdf2t_pkg.sv */
package iirdf2t_pkg;

    // Filter order; only the first ORDER delay words and b0..b_ORDER, a1..a_ORDER are used
    localparam int ORDER = 3;

    // Field widths
    localparam int ACT_W   = 2;
    localparam int SAMP_W  = 16;
    localparam int IDX_W   = 2;
    localparam int Z_W     = 40;
    localparam int COEF_W  = 18;
    localparam int FRAC    = 14;
    localparam int PROD_W  = COEF_W + SAMP_W;
    localparam int ACC_W   = Z_W + 2;

    // Coefficient register file: b0..b3 then a1..a3
    localparam int NUM_B      = 4;
    localparam int NUM_CFG    = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_B0     = 0;
    localparam int CFG_A1     = NUM_B;
    localparam logic signed [COEF_W-1:0] COEF_B0_RESET = COEF_W'(16384);

    // Tap counter and delay word address widths
    localparam int TAP_W = (ORDER > 1) ? $clog2(ORDER) : 1;
    localparam int ZA_W  = ($clog2(ORDER + 1) > IDX_W) ? $clog2(ORDER + 1) : IDX_W;

    typedef enum logic [ACT_W-1:0] {
        ACT_FILTER = 2'd0,
        ACT_LOAD   = 2'd1,
        ACT_READ   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic signed [SAMP_W-1:0] sample;
        logic [IDX_W-1:0]         delay_index;
        logic signed [Z_W-1:0]    delay_value;
    } req_t;

    typedef struct packed {
        logic signed [SAMP_W-1:0] filtered;
        logic signed [Z_W-1:0]    delay_out;
        logic                     saturated;
    } rsp_t;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_ACC_Y0,
        OP_SAT_Y,
        OP_ACC_TAP,
        OP_WRITE_TAP,
        OP_LOAD,
        OP_READ
    } dp_op_t;

    // Multiplier coefficient select, relative to the tap counter
    typedef enum logic [1:0] {
        CS_B0,
        CS_B_TAP1,
        CS_B_TAP2,
        CS_A_TAP1
    } coef_sel_t;

    // Sequencer jump kinds
    typedef enum logic [1:0] {
        J_NEXT,
        J_LOOP,
        J_GOTO,
        J_END
    } jump_t;

    localparam int PC_W = 3;

    // Program addresses
    localparam logic [PC_W-1:0] S_MB0  = 3'd0;
    localparam logic [PC_W-1:0] S_ACC0 = 3'd1;
    localparam logic [PC_W-1:0] S_SATY = 3'd2;
    localparam logic [PC_W-1:0] S_TA   = 3'd3;
    localparam logic [PC_W-1:0] S_TB   = 3'd4;
    localparam logic [PC_W-1:0] S_DONE = 3'd5;
    localparam logic [PC_W-1:0] S_LOAD = 3'd6;
    localparam logic [PC_W-1:0] S_READ = 3'd7;

    typedef struct packed {
        dp_op_t            op;
        logic              mul_en;
        coef_sel_t         coef;
        jump_t             jmp;
        logic [PC_W-1:0]   target;
    } ucode_t;

    // Sequencer to datapath control bundle
    typedef struct packed {
        dp_op_t           op;
        logic             mul_en;
        coef_sel_t        coef;
        logic [TAP_W-1:0] tap;
        logic             start;
        logic             res_load;
    } seq_ctl_t;

    // Microcode ROM
    function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
        ucode_t u;
        u = '{op: OP_NONE, mul_en: 1'b0, coef: CS_B0, jmp: J_END, target: S_DONE};
        case (pc)
            // b0*x
            S_MB0:  u = '{op: OP_NONE, mul_en: 1'b1, coef: CS_B0,
                          jmp: J_NEXT, target: S_DONE};
            // acc = b0*x + z0 + half lsb; start b1*x
            S_ACC0: u = '{op: OP_ACC_Y0, mul_en: 1'b1, coef: CS_B_TAP1,
                          jmp: J_NEXT, target: S_DONE};
            // y = sat16(acc >>> 14)
            S_SATY: u = '{op: OP_SAT_Y, mul_en: 1'b0, coef: CS_B0,
                          jmp: J_NEXT, target: S_DONE};
            // acc = b*x + z[t+1]; start a*y
            S_TA:   u = '{op: OP_ACC_TAP, mul_en: 1'b1, coef: CS_A_TAP1,
                          jmp: J_NEXT, target: S_DONE};
            // z[t] = sat40(acc - a*y); start next b*x; loop over taps
            S_TB:   u = '{op: OP_WRITE_TAP, mul_en: 1'b1, coef: CS_B_TAP2,
                          jmp: J_LOOP, target: S_TA};
            S_DONE: u = '{op: OP_NONE, mul_en: 1'b0, coef: CS_B0,
                          jmp: J_END, target: S_DONE};
            S_LOAD: u = '{op: OP_LOAD, mul_en: 1'b0, coef: CS_B0,
                          jmp: J_GOTO, target: S_DONE};
            S_READ: u = '{op: OP_READ, mul_en: 1'b0, coef: CS_B0,
                          jmp: J_GOTO, target: S_DONE};
            default: u = '{op: OP_NONE, mul_en: 1'b0, coef: CS_B0,
                           jmp: J_END, target: S_DONE};
        endcase
        return u;
    endfunction

endpackage

/* design/iirdf2t_seq.sv */
module iirdf2t_seq
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    input  logic [iirdf2t_pkg::ACT_W-1:0]    action,
    input  logic                             res_free,
    output logic                             req_ready,
    output iirdf2t_pkg::seq_ctl_t            ctl
);
    import iirdf2t_pkg::*;

    localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(ORDER - 1);

    logic             busy_reg, busy_next;
    logic [PC_W-1:0]  pc_reg, pc_next;
    logic [TAP_W-1:0] tap_reg, tap_next;
    logic [PC_W-1:0]  start_pc;
    logic             start;
    ucode_t           uw;

    assign uw        = ucode(pc_reg);
    assign req_ready = !busy_reg;
    assign start     = req_valid && !busy_reg;

    // Entry point by action
    always_comb
    begin
        case (action_t'(action))
            ACT_FILTER: start_pc = S_MB0;
            ACT_LOAD:   start_pc = S_LOAD;
            ACT_READ:   start_pc = S_READ;
            default:    start_pc = S_DONE;
        endcase
    end

    // Step counter, tap counter and jumps
    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        tap_next  = tap_reg;
        if (start)
        begin
            busy_next = 1'b1;
            pc_next   = start_pc;
            tap_next  = '0;
        end
        else if (busy_reg)
        begin
            case (uw.jmp)
                J_NEXT:
                begin
                    pc_next = pc_reg + PC_W'(1);
                end
                J_LOOP:
                begin
                    if (tap_reg != TAP_LAST)
                    begin
                        pc_next  = uw.target;
                        tap_next = tap_reg + TAP_W'(1);
                    end
                    else
                    begin
                        pc_next = pc_reg + PC_W'(1);
                    end
                end
                J_GOTO:
                begin
                    pc_next = uw.target;
                end
                J_END:
                begin
                    if (res_free)
                    begin
                        busy_next = 1'b0;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= S_DONE;
            tap_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
            tap_reg  <= tap_next;
        end
    end

    // Control word to the datapath
    always_comb
    begin
        ctl.op       = busy_reg ? uw.op : OP_NONE;
        ctl.mul_en   = busy_reg && uw.mul_en;
        ctl.coef     = uw.coef;
        ctl.tap      = tap_reg;
        ctl.start    = start;
        ctl.res_load = busy_reg && (uw.jmp == J_END) && res_free;
    end

endmodule

/* design/iirdf2t_dp.sv */
module iirdf2t_dp
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  iirdf2t_pkg::seq_ctl_t                 ctl,
    input  iirdf2t_pkg::req_t                     req,
    input  logic                                  cfg_valid,
    input  logic [iirdf2t_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic signed [iirdf2t_pkg::COEF_W-1:0] cfg_data,
    input  logic                                  rsp_ready,
    output logic                                  rsp_valid,
    output iirdf2t_pkg::rsp_t                     rsp,
    output logic                                  res_free
);
    import iirdf2t_pkg::*;

    localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (FRAC - 1);

    // Coefficients, delay words, result slot
    logic signed [COEF_W-1:0] coef_reg [NUM_CFG];
    logic signed [Z_W-1:0]    z_reg [ORDER];
    logic                     rsp_valid_reg;
    rsp_t                     rsp_reg;

    // Working registers
    logic signed [SAMP_W-1:0] x_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic signed [Z_W-1:0]    dval_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [SAMP_W-1:0] y_reg, y_next;
    logic signed [Z_W-1:0]    dout_reg;
    logic                     flag_reg;

    logic [CFG_IDX_W-1:0]     coef_idx;
    logic                     coef_ok;
    logic signed [COEF_W-1:0] coef_val;
    logic signed [SAMP_W-1:0] mul_opnd;
    logic [ZA_W-1:0]          rd_addr;
    logic signed [Z_W-1:0]    z_rd;
    logic signed [ACC_W-1:0]  y_shift;
    logic                     y_ovf;
    logic signed [ACC_W-1:0]  diff;
    logic                     z_ovf;
    logic signed [Z_W-1:0]    z_sat;
    logic                     idx_ok;

    assign res_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign idx_ok    = ZA_W'(idx_reg) < ZA_W'(ORDER);

    // Coefficient select relative to the tap counter
    always_comb
    begin
        coef_ok = 1'b1;
        case (ctl.coef)
            CS_B0:     coef_idx = CFG_IDX_W'(CFG_B0);
            CS_B_TAP1: coef_idx = CFG_IDX_W'(ctl.tap) + CFG_IDX_W'(1);
            CS_B_TAP2:
            begin
                coef_idx = CFG_IDX_W'(ctl.tap) + CFG_IDX_W'(2);
                coef_ok  = coef_idx <= CFG_IDX_W'(ORDER);
            end
            CS_A_TAP1: coef_idx = CFG_IDX_W'(ctl.tap) + CFG_IDX_W'(CFG_A1);
            default:   coef_idx = CFG_IDX_W'(CFG_B0);
        endcase
        coef_val = coef_ok ? coef_reg[coef_idx] : '0;
        mul_opnd = (ctl.coef == CS_A_TAP1) ? y_reg : x_reg;
    end

    // Shared multiplier, product registered
    assign prod_next = coef_val * mul_opnd;

    // Delay word read port
    always_comb
    begin
        case (ctl.op)
            OP_ACC_TAP: rd_addr = ZA_W'(ctl.tap) + ZA_W'(1);
            OP_READ:    rd_addr = ZA_W'(idx_reg);
            default:    rd_addr = '0;
        endcase
        z_rd = '0;
        for (int k = 0; k < ORDER; k++)
        begin
            if (rd_addr == ZA_W'(k))
            begin
                z_rd = z_reg[k];
            end
        end
    end

    // Accumulator and output rounding / saturation
    always_comb
    begin
        acc_next = acc_reg;
        case (ctl.op)
            OP_ACC_Y0:  acc_next = ACC_W'(prod_reg) + ACC_W'(z_rd) + RND;
            OP_ACC_TAP: acc_next = ACC_W'(prod_reg) + ACC_W'(z_rd);
            default:    acc_next = acc_reg;
        endcase

        y_shift = acc_reg >>> FRAC;
        y_ovf   = !((&y_shift[ACC_W-1:SAMP_W-1]) || !(|y_shift[ACC_W-1:SAMP_W-1]));
        if (y_ovf)
        begin
            y_next = y_shift[ACC_W-1] ? {1'b1, {(SAMP_W-1){1'b0}}}
                                      : {1'b0, {(SAMP_W-1){1'b1}}};
        end
        else
        begin
            y_next = y_shift[SAMP_W-1:0];
        end

        diff  = acc_reg - ACC_W'(prod_reg);
        z_ovf = !((&diff[ACC_W-1:Z_W-1]) || !(|diff[ACC_W-1:Z_W-1]));
        if (z_ovf)
        begin
            z_sat = diff[ACC_W-1] ? {1'b1, {(Z_W-1){1'b0}}}
                                  : {1'b0, {(Z_W-1){1'b1}}};
        end
        else
        begin
            z_sat = diff[Z_W-1:0];
        end
    end

    // Working registers: input capture, product, accumulator, result fields
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            x_reg    <= req.sample;
            idx_reg  <= req.delay_index;
            dval_reg <= req.delay_value;
            y_reg    <= '0;
            dout_reg <= '0;
            flag_reg <= 1'b0;
        end
        else
        begin
            case (ctl.op)
                OP_SAT_Y:
                begin
                    y_reg    <= y_next;
                    flag_reg <= flag_reg | y_ovf;
                end
                OP_WRITE_TAP:
                begin
                    flag_reg <= flag_reg | z_ovf;
                end
                OP_LOAD:
                begin
                    if (idx_ok)
                    begin
                        dout_reg <= dval_reg;
                    end
                end
                OP_READ:
                begin
                    dout_reg <= z_rd;
                end
                default:
                begin
                end
            endcase
        end
        if (ctl.mul_en)
        begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
        if (ctl.res_load)
        begin
            rsp_reg.filtered  <= y_reg;
            rsp_reg.delay_out <= dout_reg;
            rsp_reg.saturated <= flag_reg;
        end
    end

    // Coefficients, delay words and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_CFG; k++)
            begin
                coef_reg[k] <= (k == CFG_B0) ? COEF_B0_RESET : '0;
            end
            for (int k = 0; k < ORDER; k++)
            begin
                z_reg[k] <= '0;
            end
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_CFG)))
            begin
                coef_reg[cfg_index] <= cfg_data;
            end
            for (int k = 0; k < ORDER; k++)
            begin
                if ((ctl.op == OP_WRITE_TAP) && (ZA_W'(ctl.tap) == ZA_W'(k)))
                begin
                    z_reg[k] <= z_sat;
                end
                else if ((ctl.op == OP_LOAD) && (ZA_W'(idx_reg) == ZA_W'(k)))
                begin
                    z_reg[k] <= dval_reg;
                end
            end
            if (ctl.res_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* design/iir_filter_df2t.sv */
// Fixed-point IIR filter, direct form II transposed, order 3 (b0..b3, a1..a3 in
// Q4.14, a0 taken as 1). Each request word filters one 16-bit sample, loads one
// 40-bit delay word or reads one back, and gives exactly one response word. A
// sample steps through b0*x, the accumulate with z0 and the output saturation,
// then through b*x and a*y for each tap, two steps per tap, on the single shared
// 18x16 multiplier driven by a small microcoded sequencer; load and read go
// straight to their load or read step. A new request is taken only once the
// previous one has its response registered; that response waits in its own
// register, so the next request is taken while it is still pending.
// Coefficient writes are accepted every cycle but must only be made while idle.
module iir_filter_df2t
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_ready,
    input  iirdf2t_pkg::req_t                     req,
    output logic                                  rsp_valid,
    input  logic                                  rsp_ready,
    output iirdf2t_pkg::rsp_t                     rsp,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [iirdf2t_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic signed [iirdf2t_pkg::COEF_W-1:0] cfg_data
);
    import iirdf2t_pkg::*;

    seq_ctl_t ctl;
    logic     res_free;

    assign cfg_ready = 1'b1;

    // Program sequencer
    iirdf2t_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .action    (req.action),
        .res_free  (res_free),
        .req_ready (req_ready),
        .ctl       (ctl)
    );

    // Multiply-accumulate datapath and state
    iirdf2t_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .res_free  (res_free)
    );

endmodule

/* design/iirdf2t_chk.sv */
`include "iir_filter_df2t_assert.svh"

module iirdf2t_chk
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input iirdf2t_pkg::rsp_t rsp
);
    import iirdf2t_pkg::*;

    // A pending response word holds until taken
    `IIRDF2T_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    `IIRDF2T_ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_valid && !rsp_ready, $stable(rsp))

    // An accepted request occupies the sequencer
    `IIRDF2T_ASSERT_NEXT(a_busy_after_req, clk, rst_n, req_valid && req_ready, !req_ready)

    // A response only appears at the end of a busy period
    `IIRDF2T_ASSERT_NOW(a_rsp_after_busy, clk, rst_n, $rose(rsp_valid), !$past(req_ready))

    // A sample result and a delay word result never mix
    `IIRDF2T_ASSERT_NOW(a_rsp_exclusive, clk, rst_n, rsp_valid && (rsp.filtered != '0),
        rsp.delay_out == '0)

endmodule

bind iir_filter_df2t iirdf2t_chk u_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

/* sim/iir_filter_df2t_test.sv */
module iir_filter_df2t_test;
    import iirdf2t_pkg::*;

    localparam int     CYCLE_LIMIT  = 800000;
    localparam int     RANDOM_WORDS = 1450;
    localparam int     NUM_PHASES   = 6;
    localparam int     DRAIN_CYCLES = 24;
    localparam int     MAX_REPORTS  = 10;
    localparam int     COEF_MAX     = 2 ** (COEF_W - 1) - 1;
    localparam int     COEF_MIN     = -(2 ** (COEF_W - 1));
    localparam longint SAMPLE_MAX   = (64'sd1 <<< (SAMP_W - 1)) - 1;
    localparam longint SAMPLE_MIN   = -(64'sd1 <<< (SAMP_W - 1));
    localparam longint TAP_MAX      = (64'sd1 <<< (Z_W - 1)) - 1;
    localparam longint TAP_MIN      = -(64'sd1 <<< (Z_W - 1));

    // Tracks coefficients and delay words, predicts each response word
    class iir_tracker;
        longint coef_b [NUM_B];
        longint coef_a [NUM_B];   // entry 0 unused, a0 is 1
        longint taps [ORDER];
        rsp_t   pending_outputs [$];
        int     errors;
        int     n_filter, n_load, n_read, n_none, n_sat;

        function new();
            foreach (coef_b[i])
            begin
                coef_b[i] = 0;
                coef_a[i] = 0;
            end
            foreach (taps[i])
                taps[i] = 0;
            coef_b[CFG_B0] = COEF_B0_RESET;
            errors = 0;
            n_filter = 0;
            n_load = 0;
            n_read = 0;
            n_none = 0;
            n_sat = 0;
        endfunction

        function void write_coef(int idx, longint value);
            if (idx < CFG_A1)
                coef_b[idx] = value;
            else
                coef_a[idx - CFG_A1 + 1] = value;
        endfunction

        function longint clamp(longint v, longint lo, longint hi, inout bit hit);
            if (v > hi)
            begin
                hit = 1'b1;
                return hi;
            end
            if (v < lo)
            begin
                hit = 1'b1;
                return lo;
            end
            return v;
        endfunction

        // Run one accepted request word through the filter state
        function void accept_input(req_t w);
            rsp_t   r;
            longint x, y, acc;
            bit     hit;
            int     idx;
            r = '0;
            hit = 1'b0;
            idx = w.delay_index;
            case (w.action)
                ACT_FILTER:
                begin
                    n_filter++;
                    x = longint'($signed(w.sample));
                    acc = coef_b[0] * x + taps[0] + (64'sd1 <<< (FRAC - 1));
                    y = clamp(acc >>> FRAC, SAMPLE_MIN, SAMPLE_MAX, hit);
                    // transposed update, old z[i+1] feeds z[i]
                    for (int i = 0; i < ORDER; i++)
                    begin
                        acc = coef_b[i + 1] * x - coef_a[i + 1] * y;
                        if (i + 1 < ORDER)
                            acc += taps[i + 1];
                        taps[i] = clamp(acc, TAP_MIN, TAP_MAX, hit);
                    end
                    r.filtered = y[SAMP_W-1:0];
                    r.saturated = hit;
                end
                ACT_LOAD:
                begin
                    n_load++;
                    if (idx < ORDER)
                    begin
                        taps[idx] = longint'($signed(w.delay_value));
                        r.delay_out = w.delay_value;
                    end
                end
                ACT_READ:
                begin
                    n_read++;
                    if (idx < ORDER)
                        r.delay_out = taps[idx][Z_W-1:0];
                end
                default:
                    n_none++;
            endcase
            if (hit)
                n_sat++;
            pending_outputs.push_back(r);
        endfunction

        // Compare one response word against the oldest prediction
        function void check_output(rsp_t got);
            rsp_t want;
            if (pending_outputs.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected response word: filtered %0d delay_out %0d sat %0b",
                             got.filtered, got.delay_out, got.saturated);
                return;
            end
            want = pending_outputs.pop_front();
            if (got.filtered !== want.filtered || got.delay_out !== want.delay_out ||
                got.saturated !== want.saturated)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("bad response word: filtered %0d/%0d delay_out %0d/%0d sat %0b/%0b %s",
                             want.filtered, got.filtered, want.delay_out, got.delay_out,
                             want.saturated, got.saturated, "(expected/actual)");
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     req_valid;
    logic                     req_ready;
    req_t                     req;
    logic                     rsp_valid;
    logic                     rsp_ready = 1'b0;
    rsp_t                     rsp;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic signed [COEF_W-1:0] cfg_data;

    iir_tracker sb;
    int         cycles = 0;
    bit         steady;
    int         ready_left = 0;
    int         settings_used = 0;

    iir_filter_df2t i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Response side back-pressure: runs of ready, short stalls, rare long ones
    always @(posedge clk)
    begin
        if (steady)
            rsp_ready <= 1'b1;
        else if (ready_left > 0)
            ready_left <= ready_left - 1;
        else if ($urandom_range(0, 99) < 65)
        begin
            rsp_ready <= 1'b1;
            ready_left <= $urandom_range(1, 20);
        end
        else
        begin
            rsp_ready <= 1'b0;
            ready_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 2);
        end
    end

    // Response check and watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_output(rsp);
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("iir_filter_df2t: mismatch");
            $finish;
        end
    end

    function automatic req_t pack_req(action_t a, longint s, int idx, longint v);
        req_t w;
        w.action = a;
        w.sample = SAMP_W'(s);
        w.delay_index = IDX_W'(idx);
        w.delay_value = Z_W'(v);
        return w;
    endfunction

    function automatic req_t random_word();
        req_t        w;
        logic [63:0] bits;
        int          p;
        p = $urandom_range(0, 99);
        if (p < 68)
            w.action = ACT_FILTER;
        else if (p < 82)
            w.action = ACT_LOAD;
        else if (p < 95)
            w.action = ACT_READ;
        else
            w.action = ACT_NONE;
        // sample: mostly full range, some extremes and small values
        p = $urandom_range(0, 9);
        if (p == 0)
            w.sample = SAMP_W'(SAMPLE_MAX);
        else if (p == 1)
            w.sample = SAMP_W'(SAMPLE_MIN);
        else if (p < 4)
            w.sample = SAMP_W'($urandom_range(0, 255) - 128);
        else
            w.sample = SAMP_W'($urandom);
        w.delay_index = ($urandom_range(0, 11) == 0) ? IDX_W'(3)
                                                      : IDX_W'($urandom_range(0, ORDER - 1));
        bits = {$urandom, $urandom};
        p = $urandom_range(0, 9);
        if (p == 0)
            w.delay_value = Z_W'(TAP_MAX);
        else if (p == 1)
            w.delay_value = Z_W'(TAP_MIN);
        else if (p < 6)
            w.delay_value = $signed(bits[29:0]);
        else
            w.delay_value = bits[Z_W-1:0];
        return w;
    endfunction

    function automatic int coef_setting(int phase, int k);
        case (phase)
            1: return COEF_MAX;
            2: return COEF_MIN;
            3:
            begin
                // gentle third-order low-pass
                case (k)
                    CFG_B0:     return 1024;
                    CFG_B0 + 1: return 3072;
                    CFG_B0 + 2: return 3072;
                    CFG_B0 + 3: return 1024;
                    CFG_A1:     return -19661;
                    CFG_A1 + 1: return 8192;
                    default:    return -1638;
                endcase
            end
            5: return 0;
            6: return (k == CFG_B0) ? COEF_MIN : $urandom_range(0, 8191) - 4096;
            default: return $urandom;
        endcase
    endfunction

    // Hold a request word until the block takes it
    task automatic send_word(input req_t w);
        req_valid <= 1'b1;
        req <= w;
        do
            @(posedge clk);
        while (!req_ready);
        sb.accept_input(w);
    endtask

    task automatic sender_gap();
        int n;
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            n = 0;
        else if (r < 92)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(10, 50);
        if (n > 0)
        begin
            req_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Stop sending until every predicted word has come back
    task automatic drain();
        if (sb.pending_outputs.size() != 0)
        begin
            req_valid <= 1'b0;
            while (sb.pending_outputs.size() != 0)
                @(posedge clk);
        end
    endtask

    task automatic write_coef(input int idx, input int value);
        logic signed [COEF_W-1:0] c;
        c = COEF_W'(value);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IDX_W'(idx);
        cfg_data <= c;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_coef(idx, c);
    endtask

    initial
    begin
        req_t directed [$];
        sb = new();
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        steady = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words under reset coefficients (pass-through, b0 = 1)
        directed.push_back(pack_req(ACT_READ, 0, 0, 0));
        directed.push_back(pack_req(ACT_READ, 0, 3, 0));
        directed.push_back(pack_req(ACT_LOAD, 0, 0, TAP_MAX));
        directed.push_back(pack_req(ACT_LOAD, 0, 1, TAP_MIN));
        directed.push_back(pack_req(ACT_LOAD, 0, 2, -1));
        directed.push_back(pack_req(ACT_LOAD, 0, 3, 12345));  // ignored, index past order
        directed.push_back(pack_req(ACT_READ, 0, 0, 0));
        directed.push_back(pack_req(ACT_READ, 0, 1, 0));
        directed.push_back(pack_req(ACT_READ, 0, 2, 0));
        directed.push_back(pack_req(ACT_READ, 0, 3, 0));
        directed.push_back(pack_req(ACT_FILTER, 0, 0, 0));      // y clips high
        directed.push_back(pack_req(ACT_FILTER, SAMPLE_MAX, 0, 0));  // y clips low
        directed.push_back(pack_req(ACT_FILTER, SAMPLE_MIN, 0, 0));
        directed.push_back(pack_req(ACT_FILTER, -1, 0, 0));
        directed.push_back(pack_req(ACT_FILTER, 1, 0, 0));
        directed.push_back(pack_req(ACT_NONE, SAMPLE_MAX, 1, -1));  // unused action
        // rounding ties go up
        directed.push_back(pack_req(ACT_LOAD, 0, 0, 8192));
        directed.push_back(pack_req(ACT_FILTER, 0, 0, 0));
        directed.push_back(pack_req(ACT_LOAD, 0, 0, -8192));
        directed.push_back(pack_req(ACT_FILTER, 0, 0, 0));
        directed.push_back(pack_req(ACT_LOAD, 0, 0, TAP_MIN));
        directed.push_back(pack_req(ACT_FILTER, SAMPLE_MIN, 0, 0));
        directed.push_back(pack_req(ACT_READ, 0, 0, 0));
        foreach (directed[i])
        begin
            send_word(directed[i]);
            sender_gap();
        end

        // Random phases, each under its own coefficient set
        for (int phase = 1; phase <= NUM_PHASES; phase++)
        begin
            drain();
            steady <= (phase == 3);
            for (int k = CFG_B0; k < NUM_CFG; k++)
                write_coef(k, coef_setting(phase, k));
            cfg_valid <= 1'b0;
            settings_used++;
            for (int n = 0; n < RANDOM_WORDS / NUM_PHASES; n++)
            begin
                if (n == 120)
                    drain();
                send_word(random_word());
                sender_gap();
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("ran %0d filter, %0d load, %0d read and %0d unused-action words",
                 sb.n_filter, sb.n_load, sb.n_read, sb.n_none);
        $display("over reset plus %0d coefficient sets; %0d words saturated, %0d failures",
                 settings_used, sb.n_sat, sb.errors);
        if (sb.errors == 0 && sb.pending_outputs.size() == 0)
            $display("iir_filter_df2t: match");
        else
            $display("iir_filter_df2t: mismatch");
        $finish;
    end

endmodule
